[src/vector_field_angle_error_stats_unit_defines.svh]
// Assertion macros for the angle error statistics unit
`ifndef VECTOR_FIELD_ANGLE_ERROR_STATS_UNIT_DEFINES_SVH
`define VECTOR_FIELD_ANGLE_ERROR_STATS_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define VFAES_ASSERT_NOW(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VFAES_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

[src/vfaes_pkg.sv]
// Shared types, constants and helper functions of the angle error statistics unit
package vfaes_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int COMP_BITS   = 16;
   localparam int GRAY_BITS   = 15;
   localparam int ANGLE_BITS  = 15;
   localparam int TOL_BITS    = 20;
   localparam int STATUS_BITS = 3;
   localparam int HORNER_TERMS = 8;

   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 15'd23040;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [31:0] RAD_PER_DEG_Q32 = 32'd74961320;
   localparam logic signed [33:0] Q30_ONE = 34'sh040000000;
   localparam logic [33:0] UNIT_SQ = 34'h010000000;

   localparam logic [STATUS_BITS-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OUTSIDE     = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DIR_INVALID = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_REF_INVALID = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_DIR_MAG     = 3'd4;
   localparam logic [STATUS_BITS-1:0] STATUS_REF_MAG     = 3'd5;

   localparam logic [1:0] REG_CUTOFF_LOW  = 2'd0;
   localparam logic [1:0] REG_CUTOFF_HIGH = 2'd1;
   localparam logic [1:0] REG_MAG_TOL     = 2'd2;

   typedef struct packed {
      logic [GRAY_BITS-1:0]        gray_value;
      logic signed [COMP_BITS-1:0] dir_x;
      logic signed [COMP_BITS-1:0] dir_y;
      logic signed [COMP_BITS-1:0] dir_z;
      logic                        dir_valid;
      logic signed [COMP_BITS-1:0] ref_x;
      logic signed [COMP_BITS-1:0] ref_y;
      logic signed [COMP_BITS-1:0] ref_z;
      logic                        ref_valid;
      logic                        last_voxel;
   } req_type;

   typedef struct packed {
      logic                    result_kind;
      logic [ANGLE_BITS-1:0]   angle;
      logic [STATUS_BITS-1:0]  voxel_status;
      logic [ANGLE_BITS-1:0]   mean_angle;
      logic [ANGLE_BITS-1:0]   sd_angle;
      logic [COUNT_BITS-1:0]   ok_count;
      logic [COUNT_BITS-1:0]   considered_count;
      logic [COUNT_BITS-1:0]   dir_invalid_count;
      logic [COUNT_BITS-1:0]   ref_invalid_count;
      logic [COUNT_BITS-1:0]   dir_magnitude_count;
      logic [COUNT_BITS-1:0]   ref_magnitude_count;
      logic                    last_result;
   } rsp_type;

   typedef struct packed {
      logic [GRAY_BITS-1:0] cutoff_low;
      logic [GRAY_BITS-1:0] cutoff_high;
      logic [TOL_BITS-1:0]  tolerance;
   } cfg_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [COMP_BITS-1:0] abs_comp(input logic signed [COMP_BITS-1:0] x);
      return x[COMP_BITS-1] ? COMP_BITS'(-x) : COMP_BITS'(x);
   endfunction

   // Taylor divisors of the cosine Horner chain
   function automatic logic [7:0] horner_div(input logic [2:0] i);
      logic [7:0] d;
      case (i)
         3'd0: d = 8'd240;
         3'd1: d = 8'd182;
         3'd2: d = 8'd132;
         3'd3: d = 8'd90;
         3'd4: d = 8'd56;
         3'd5: d = 8'd30;
         3'd6: d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor)
   function automatic logic [31:0] horner_recip(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'd17895697;
         3'd1: r = 32'd23598721;
         3'd2: r = 32'd32537631;
         3'd3: r = 32'd47721858;
         3'd4: r = 32'd76695844;
         3'd5: r = 32'd143165576;
         3'd6: r = 32'd357913941;
         default: r = 32'd2147483648;
      endcase
      return r;
   endfunction

endpackage

[src/vfaes_csr.sv]
// Configuration register file with APB-style access
module vfaes_csr import vfaes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_CUTOFF_LOW:  cfg_in.cutoff_low  = csr_pwdata[GRAY_BITS-1:0];
            REG_CUTOFF_HIGH: cfg_in.cutoff_high = csr_pwdata[GRAY_BITS-1:0];
            REG_MAG_TOL:     cfg_in.tolerance   = csr_pwdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CUTOFF_LOW:  csr_prdata = 32'(cfg_ff.cutoff_low);
         REG_CUTOFF_HIGH: csr_prdata = 32'(cfg_ff.cutoff_high);
         REG_MAG_TOL:     csr_prdata = 32'(cfg_ff.tolerance);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff_low  <= '0;
         cfg_ff.cutoff_high <= 15'd32767;
         cfg_ff.tolerance   <= 20'd53687;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/vector_field_angle_error_stats_unit.sv]
// Top level: per-voxel angular error and end-of-volume mean and deviation
// An out-of-window or invalid voxel is answered after the check, a magnitude fault after its
// magnitude sum; an ok voxel runs 14 or 15 bisection steps of an 8-term cosine on one
// shared 33x32 multiplier, and a summary adds 3 serial divides and an integer square root.
// One request at a time: next request accepted once the previous one is finished.
// Reset (synchronous) restores the register defaults and clears all sums and counts.
`include "vector_field_angle_error_stats_unit_defines.svh"
module vector_field_angle_error_stats_unit import vfaes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_MAG_MUL, ST_MAG_ACC, ST_DOT_MUL, ST_DOT_ACC, ST_CLAMP,
      ST_BS_MID, ST_R30_MUL, ST_R2_MUL, ST_R2_GET, ST_H_MUL, ST_H_REC, ST_H_EST,
      ST_H_SUB, ST_H_FIX, ST_BS_CMP, ST_ANG_SQ, ST_UPDATE, ST_EMIT_VOX,
      ST_DIV_INIT, ST_DIV_STEP, ST_M1SQ, ST_VAR, ST_SQRT, ST_SD, ST_EMIT_SUM
   } state_type;

   cfg_type cfg;

   vfaes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [ANGLE_BITS-1:0]  angle_ff, angle_in;
   logic [5:0]             step_ff, step_in;
   logic signed [34:0]     acc_ff, acc_in;
   logic [64:0]            prod_ff, prod_in;
   logic [ANGLE_BITS-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [30:0]            dq_ff, dq_in;
   logic [31:0]            r2_ff, r2_in;
   logic signed [33:0]     t_ff, t_in;
   logic [32:0]            q_ff, q_in, est_ff, est_in;
   logic [38:0]            sum_ff, sum_in;
   logic [53:0]            sq_ff, sq_in;
   logic [COUNT_BITS-1:0]  ok_ff, ok_in, cons_ff, cons_in;
   logic [COUNT_BITS-1:0]  fault_ff [4];
   logic [COUNT_BITS-1:0]  fault_in [4];
   logic [1:0]             div_sel_ff, div_sel_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [61:0]            quo_ff, quo_in;
   logic [ANGLE_BITS-1:0]  mean_ff, mean_in, sd_ff, sd_in;
   logic [19:0]            m1_ff, m1_in;
   logic [61:0]            v_ff, v_in;
   logic [62:0]            root_ff, root_in, bit_ff, bit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [32:0]            mul_a;
   logic [31:0]            mul_b;
   logic signed [COMP_BITS-1:0] sel_comp, dir_comp, ref_comp;
   logic [33:0]            m2, diff;
   logic [34:0]            dabs;
   logic [15:0]            mid_sum;
   logic [24:0]            div_rs, div_sub;
   logic                   div_ge;
   logic [61:0]            quo_new;
   logic [62:0]            sqrt_tst;
   logic [31:0]            sd_round;
   logic                   rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign prod_in   = 65'(mul_a) * 65'(mul_b);

   always_comb begin
      case (step_ff[2:0])
         3'd0: sel_comp = req_ff.dir_x;
         3'd1: sel_comp = req_ff.dir_y;
         3'd2: sel_comp = req_ff.dir_z;
         3'd3: sel_comp = req_ff.ref_x;
         3'd4: sel_comp = req_ff.ref_y;
         default: sel_comp = req_ff.ref_z;
      endcase
      case (step_ff[1:0])
         2'd0: begin
            dir_comp = req_ff.dir_x;
            ref_comp = req_ff.ref_x;
         end
         2'd1: begin
            dir_comp = req_ff.dir_y;
            ref_comp = req_ff.ref_y;
         end
         default: begin
            dir_comp = req_ff.dir_z;
            ref_comp = req_ff.ref_z;
         end
      endcase
   end

   always_comb begin
      m2       = 34'(acc_ff[32:0]) + 34'(prod_ff[32:0]);
      diff     = (m2 > UNIT_SQ) ? m2 - UNIT_SQ : UNIT_SQ - m2;
      dabs     = acc_ff[34] ? 35'(-acc_ff) : 35'(acc_ff);
      mid_sum  = 16'(lo_ff) + 16'(hi_ff);
      div_rs   = {rem_ff, quo_ff[61]};
      div_ge   = div_rs >= 25'(ok_ff);
      div_sub  = div_ge ? div_rs - 25'(ok_ff) : div_rs;
      quo_new  = {quo_ff[60:0], div_ge};
      sqrt_tst = root_ff + bit_ff;
      sd_round = (root_ff[31:0] + 32'd8) >> 4;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      angle_in     = angle_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      dq_in        = dq_ff;
      r2_in        = r2_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      est_in       = est_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      ok_in        = ok_ff;
      cons_in      = cons_ff;
      fault_in     = fault_ff;
      div_sel_in   = div_sel_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mean_in      = mean_ff;
      sd_in        = sd_ff;
      m1_in        = m1_ff;
      v_in         = v_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               angle_in  = '0;
               status_in = STATUS_OK;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (req_ff.gray_value < cfg.cutoff_low || req_ff.gray_value > cfg.cutoff_high) begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_EMIT_VOX;
            end else begin
               cons_in = sat_inc(cons_ff);
               if (!req_ff.dir_valid) begin
                  status_in   = STATUS_DIR_INVALID;
                  fault_in[0] = sat_inc(fault_ff[0]);
                  state_in    = ST_EMIT_VOX;
               end else if (!req_ff.ref_valid) begin
                  status_in   = STATUS_REF_INVALID;
                  fault_in[1] = sat_inc(fault_ff[1]);
                  state_in    = ST_EMIT_VOX;
               end else begin
                  acc_in   = '0;
                  step_in  = '0;
                  state_in = ST_MAG_MUL;
               end
            end
         end
         ST_MAG_MUL: begin
            mul_a    = 33'(abs_comp(sel_comp));
            mul_b    = 32'(abs_comp(sel_comp));
            state_in = ST_MAG_ACC;
         end
         ST_MAG_ACC: begin
            if (step_ff == 6'd2 || step_ff == 6'd5) begin
               if (diff > 34'(cfg.tolerance)) begin
                  if (step_ff == 6'd2) begin
                     status_in   = STATUS_DIR_MAG;
                     fault_in[2] = sat_inc(fault_ff[2]);
                  end else begin
                     status_in   = STATUS_REF_MAG;
                     fault_in[3] = sat_inc(fault_ff[3]);
                  end
                  state_in = ST_EMIT_VOX;
               end else begin
                  acc_in   = '0;
                  step_in  = (step_ff == 6'd2) ? 6'd3 : 6'd0;
                  state_in = (step_ff == 6'd2) ? ST_MAG_MUL : ST_DOT_MUL;
               end
            end else begin
               acc_in   = 35'(m2);
               step_in  = step_ff + 6'd1;
               state_in = ST_MAG_MUL;
            end
         end
         ST_DOT_MUL: begin
            mul_a    = 33'(abs_comp(dir_comp));
            mul_b    = 32'(abs_comp(ref_comp));
            state_in = ST_DOT_ACC;
         end
         ST_DOT_ACC: begin
            if (dir_comp[COMP_BITS-1] ^ ref_comp[COMP_BITS-1]) begin
               acc_in = acc_ff - $signed({4'b0, prod_ff[30:0]});
            end else begin
               acc_in = acc_ff + $signed({4'b0, prod_ff[30:0]});
            end
            step_in  = step_ff + 6'd1;
            state_in = (step_ff == 6'd2) ? ST_CLAMP : ST_DOT_MUL;
         end
         ST_CLAMP: begin
            dq_in    = (dabs > 35'(UNIT_SQ)) ? {UNIT_SQ[28:0], 2'b00} : {dabs[28:0], 2'b00};
            lo_in    = '0;
            hi_in    = ANGLE_MAX;
            state_in = ST_BS_MID;
         end
         ST_BS_MID: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[15:1];
               state_in = ST_R30_MUL;
            end else begin
               angle_in = lo_ff;
               state_in = ST_ANG_SQ;
            end
         end
         ST_R30_MUL: begin
            mul_a    = 33'({mid_ff, 1'b1});
            mul_b    = RAD_PER_DEG_Q32;
            state_in = ST_R2_MUL;
         end
         ST_R2_MUL: begin
            mul_a    = 33'(prod_ff[41:11]);
            mul_b    = 32'(prod_ff[41:11]);
            state_in = ST_R2_GET;
         end
         ST_R2_GET: begin
            r2_in    = prod_ff[61:30];
            t_in     = Q30_ONE;
            step_in  = '0;
            state_in = ST_H_MUL;
         end
         ST_H_MUL: begin
            mul_a    = t_ff[33] ? 33'(-t_ff) : 33'(t_ff);
            mul_b    = r2_ff;
            state_in = ST_H_REC;
         end
         ST_H_REC: begin
            q_in     = prod_ff[62:30];
            mul_a    = prod_ff[62:30];
            mul_b    = horner_recip(step_ff[2:0]);
            state_in = ST_H_EST;
         end
         ST_H_EST: begin
            est_in   = prod_ff[64:32];
            mul_a    = prod_ff[64:32];
            mul_b    = 32'(horner_div(step_ff[2:0]));
            state_in = ST_H_SUB;
         end
         ST_H_SUB: begin
            q_in     = q_ff - prod_ff[32:0];
            state_in = ST_H_FIX;
         end
         ST_H_FIX: begin
            if (q_ff >= 33'(horner_div(step_ff[2:0]))) begin
               q_in   = q_ff - 33'(horner_div(step_ff[2:0]));
               est_in = est_ff + 33'd1;
            end else begin
               t_in     = t_ff[33] ? Q30_ONE + $signed({1'b0, est_ff})
                                   : Q30_ONE - $signed({1'b0, est_ff});
               step_in  = step_ff + 6'd1;
               state_in = (step_ff == 6'(HORNER_TERMS - 1)) ? ST_BS_CMP : ST_H_MUL;
            end
         end
         ST_BS_CMP: begin
            if (t_ff <= $signed({3'b000, dq_ff})) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = ST_BS_MID;
         end
         ST_ANG_SQ: begin
            mul_a    = 33'(angle_ff);
            mul_b    = 32'(angle_ff);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (ok_ff != COUNT_MAX) begin
               ok_in  = ok_ff + 1'b1;
               sum_in = sum_ff + 39'(angle_ff);
               sq_in  = sq_ff + 54'(prod_ff[29:0]);
            end
            state_in = ST_EMIT_VOX;
         end
         ST_EMIT_VOX: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.angle        = angle_ff;
               rsp_in.voxel_status = status_ff;
               div_sel_in          = '0;
               if (!req_ff.last_voxel) begin
                  state_in = ST_IDLE;
               end else if (ok_ff == '0) begin
                  mean_in  = '0;
                  sd_in    = '0;
                  state_in = ST_EMIT_SUM;
               end else begin
                  state_in = ST_DIV_INIT;
               end
            end
         end
         ST_DIV_INIT: begin
            rem_in  = '0;
            step_in = '0;
            case (div_sel_ff)
               2'd0:    quo_in = 62'(sum_ff) + 62'(ok_ff[COUNT_BITS-1:1]);
               2'd1:    quo_in = 62'({sum_ff, 4'b0000}) + 62'(ok_ff[COUNT_BITS-1:1]);
               default: quo_in = {sq_ff, 8'h00};
            endcase
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            rem_in  = div_sub[COUNT_BITS-1:0];
            quo_in  = quo_new;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd61) begin
               case (div_sel_ff)
                  2'd0: begin
                     mean_in    = (quo_new > 62'(ANGLE_MAX)) ? ANGLE_MAX : quo_new[14:0];
                     div_sel_in = 2'd1;
                     state_in   = ST_DIV_INIT;
                  end
                  2'd1: begin
                     m1_in      = quo_new[19:0];
                     div_sel_in = 2'd2;
                     state_in   = ST_DIV_INIT;
                  end
                  default: state_in = ST_M1SQ;
               endcase
            end
         end
         ST_M1SQ: begin
            mul_a    = 33'(m1_ff);
            mul_b    = 32'(m1_ff);
            state_in = ST_VAR;
         end
         ST_VAR: begin
            v_in     = (quo_ff > prod_ff[61:0]) ? quo_ff - prod_ff[61:0] : '0;
            root_in  = '0;
            bit_in   = 63'(1) << 62;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (63'(v_ff) >= sqrt_tst) begin
               v_in    = 62'(63'(v_ff) - sqrt_tst);
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in   = bit_ff >> 2;
            step_in  = step_ff + 6'd1;
            state_in = (step_ff == 6'd31) ? ST_SD : ST_SQRT;
         end
         ST_SD: begin
            sd_in    = (sd_round > 32'(ANGLE_MAX)) ? ANGLE_MAX : sd_round[14:0];
            state_in = ST_EMIT_SUM;
         end
         ST_EMIT_SUM: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_in                     = '0;
               rsp_in.result_kind         = 1'b1;
               rsp_in.mean_angle          = mean_ff;
               rsp_in.sd_angle            = sd_ff;
               rsp_in.ok_count            = ok_ff;
               rsp_in.considered_count    = cons_ff;
               rsp_in.dir_invalid_count   = fault_ff[0];
               rsp_in.ref_invalid_count   = fault_ff[1];
               rsp_in.dir_magnitude_count = fault_ff[2];
               rsp_in.ref_magnitude_count = fault_ff[3];
               rsp_in.last_result         = 1'b1;
               sum_in   = '0;
               sq_in    = '0;
               ok_in    = '0;
               cons_in  = '0;
               fault_in = '{default: '0};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         ok_ff        <= '0;
         cons_ff      <= '0;
         fault_ff     <= '{default: '0};
         div_sel_ff   <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         ok_ff        <= ok_in;
         cons_ff      <= cons_in;
         fault_ff     <= fault_in;
         div_sel_ff   <= div_sel_in;
         step_ff      <= step_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      angle_ff  <= angle_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      dq_ff     <= dq_in;
      r2_ff     <= r2_in;
      t_ff      <= t_in;
      q_ff      <= q_in;
      est_ff    <= est_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      m1_ff     <= m1_in;
      v_ff      <= v_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      rsp_ff    <= rsp_in;
   end

   `VFAES_ASSERT_NOW(a_ok_within_considered, ok_ff <= cons_ff, "ok count exceeds considered count")
   `VFAES_ASSERT_IMP(a_bisect_order, state_ff == ST_BS_MID, lo_ff <= hi_ff, "bisection bounds crossed")
   `VFAES_ASSERT_IMP(a_voxel_status, rsp_valid && !rsp_data.result_kind, rsp_data.voxel_status <= STATUS_REF_MAG, "bad voxel status")
   `VFAES_ASSERT_IMP(a_summary_range, rsp_valid && rsp_data.result_kind, rsp_data.mean_angle <= ANGLE_MAX && rsp_data.sd_angle <= ANGLE_MAX, "summary out of range")

endmodule

[tb/tb_vector_field_angle_error_stats_unit.sv]
// Testbench of the angle error statistics unit: directed and random voxels checked against a behavioral predictor
module tb_vector_field_angle_error_stats_unit;
   import vfaes_pkg::*;

   class angle_stats_board;
      logic [14:0] cut_lo, cut_hi;
      logic [19:0] mag_tol;
      logic [63:0] sum, sq_sum, n_ok, n_cons;
      logic [63:0] faults [4];
      rsp_type pending [$];
      int errors;

      function void clear_stats();
         sum = 0; sq_sum = 0; n_ok = 0; n_cons = 0;
         foreach (faults[i]) faults[i] = 0;
      endfunction

      function void init();
         cut_lo = 0; cut_hi = 15'h7fff; mag_tol = 20'd53687; errors = 0;
         clear_stats();
      endfunction

      function longint cos_q30(longint m);
         longint r30, r2, t, dv [8];
         dv = '{240, 182, 132, 90, 56, 30, 12, 2};
         r30 = ((2 * m + 1) * 74961320) >>> 11;
         r2 = (r30 * r30) >>> 30;
         t = 64'sd1 << 30;
         for (int i = 0; i < 8; i++) t = (64'sd1 << 30) - (r2 * t) / (dv[i] * (64'sd1 << 30));
         return t;
      endfunction

      function logic [63:0] root(logic [63:0] v);
         logic [63:0] r, b;
         r = 0; b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b; r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function bit off_unit(longint x, longint y, longint z);
         longint m2, d;
         m2 = x * x + y * y + z * z;
         d = m2 - (64'sd1 << 28);
         if (d < 0) d = -d;
         return d > longint'(mag_tol);
      endfunction

      function logic [63:0] bump(logic [63:0] c);
         return c < 64'hffffff ? c + 1 : c;
      endfunction

      function void note_request(req_type q);
         rsp_type v, s;
         longint dot, lo, hi, mid;
         logic [63:0] e2, m1, mn, sd;
         v = '0;
         if (q.gray_value < cut_lo || q.gray_value > cut_hi) begin
            v.voxel_status = STATUS_OUTSIDE;
         end else begin
            n_cons = bump(n_cons);
            if (!q.dir_valid) v.voxel_status = STATUS_DIR_INVALID;
            else if (!q.ref_valid) v.voxel_status = STATUS_REF_INVALID;
            else if (off_unit(q.dir_x, q.dir_y, q.dir_z)) v.voxel_status = STATUS_DIR_MAG;
            else if (off_unit(q.ref_x, q.ref_y, q.ref_z)) v.voxel_status = STATUS_REF_MAG;
            else v.voxel_status = STATUS_OK;
            if (v.voxel_status != STATUS_OK) begin
               faults[v.voxel_status - 2] = bump(faults[v.voxel_status - 2]);
            end else begin
               dot = longint'(q.dir_x) * q.ref_x + longint'(q.dir_y) * q.ref_y
                     + longint'(q.dir_z) * q.ref_z;
               if (dot < 0) dot = -dot;
               if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
               dot <<= 2;
               lo = 0; hi = 23040;
               while (lo < hi) begin
                  mid = (lo + hi) >> 1;
                  if (cos_q30(mid) <= dot) hi = mid;
                  else lo = mid + 1;
               end
               v.angle = 15'(lo);
               if (n_ok < 64'hffffff) begin
                  n_ok++; sum += lo; sq_sum += lo * lo;
               end
            end
         end
         pending.push_back(v);
         if (!q.last_voxel) return;
         s = '0; mn = 0; sd = 0;
         if (n_ok != 0) begin
            e2 = (sq_sum << 8) / n_ok;
            m1 = ((sum << 4) + n_ok / 2) / n_ok;
            e2 = e2 > m1 * m1 ? e2 - m1 * m1 : 0;
            mn = (sum + n_ok / 2) / n_ok;
            sd = (root(e2) + 8) >> 4;
            if (mn > 23040) mn = 23040;
            if (sd > 23040) sd = 23040;
         end
         s.result_kind = 1; s.mean_angle = 15'(mn); s.sd_angle = 15'(sd);
         s.ok_count = 24'(n_ok); s.considered_count = 24'(n_cons);
         s.dir_invalid_count = 24'(faults[0]); s.ref_invalid_count = 24'(faults[1]);
         s.dir_magnitude_count = 24'(faults[2]); s.ref_magnitude_count = 24'(faults[3]);
         s.last_result = 1;
         pending.push_back(s);
         clear_stats();
      endfunction

      function void check_result(rsp_type got);
         rsp_type w;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got !== w) begin
            $display("%0t mismatch expected %h actual %h", $time, w, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [3:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   angle_stats_board board = new();
   int idle_cycles = 0;
   bit hold_off = 0;

   vector_field_angle_error_stats_unit dut (.*);

   always #5 clock = ~clock;

   // result check and watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_stall <= reset ? 1'b0 : 1'b1;
      else rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_CUTOFF_LOW: board.cut_lo = val[14:0];
         REG_CUTOFF_HIGH: board.cut_hi = val[14:0];
         default: board.mag_tol = val[19:0];
      endcase
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   function automatic req_type make_voxel(int mode);
      req_type q;
      int k;
      q = '0;
      q.gray_value = 15'($urandom);
      q.dir_valid = $urandom_range(0, 15) != 0;
      q.ref_valid = $urandom_range(0, 15) != 0;
      q.last_voxel = $urandom_range(0, 11) == 0;
      k = $urandom_range(0, 5);
      if (mode == 0 || k == 0) begin
         {q.dir_x, q.dir_y, q.dir_z, q.ref_x, q.ref_y, q.ref_z} = {$urandom, $urandom, $urandom};
      end else begin
         // unit axes with small random perturbation, random signs
         q.dir_x = 16'sd16384 - 16'($urandom_range(0, 3000));
         q.dir_y = $urandom_range(0, 2) == 0 ? 16'sd0 : 16'($signed($urandom_range(0, 6000)) - 3000);
         q.dir_z = 16'($urandom_range(0, 7));
         q.ref_x = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         q.ref_y = $urandom_range(0, 1) ? 16'sd0 : 16'sd2;
         q.ref_z = '0;
         if ($urandom_range(0, 1)) {q.dir_x, q.ref_y} = {q.ref_y, q.dir_x};
         if ($urandom_range(0, 1)) q.dir_x = -q.dir_x;
      end
      return q;
   endfunction

   task automatic send(input req_type q);
      @(negedge clock);
      req_valid <= 1; req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
      if ($urandom_range(0, 2) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 60) : $urandom_range(0, 3))
            @(negedge clock);
      end
   endtask

   task automatic push(input req_type q);
      @(negedge clock);
      req_valid <= 1; req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
   endtask

   initial begin
      req_type q;
      board.init();
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 0;
      q = '0; q.dir_valid = 1; q.ref_valid = 1;
      q.dir_x = 16'sd16384; q.ref_x = 16'sd16384; push(q);
      q.ref_x = -16'sd16384; push(q);
      q.ref_x = '0; q.ref_y = 16'sd16384; push(q);
      q.dir_x = 16'sd11585; q.dir_y = 16'sd11585; q.ref_y = '0; q.ref_x = 16'sd16384; push(q);
      q.dir_x = 16'sh8000; q.dir_y = 16'sh7fff; q.dir_z = 16'sh8000; push(q);
      q.dir_x = 16'sd16384; q.dir_y = '0; q.dir_z = '0; q.ref_x = 16'sh7fff;
      q.ref_z = 16'sh7fff; push(q);
      q.ref_x = 16'sd16384; q.ref_z = '0; q.dir_valid = 0; push(q);
      q.dir_valid = 1; q.ref_valid = 0; push(q);
      q.ref_valid = 1; q.gray_value = 15'h7fff; push(q);
      q.last_voxel = 1; push(q);
      q.last_voxel = 1; q.dir_valid = 0; push(q);
      q = '0; q.last_voxel = 1; push(q);
      @(negedge clock) req_valid <= 0;
      drain();
      write_reg(REG_CUTOFF_LOW, 32'h7fff); write_reg(REG_CUTOFF_HIGH, 32'd0);
      write_reg(REG_MAG_TOL, 32'hfffff);
      q = '0; q.gray_value = 15'h7fff; q.last_voxel = 1; push(q);
      @(negedge clock) req_valid <= 0;
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin write_reg(REG_CUTOFF_LOW, 32'd0); write_reg(REG_CUTOFF_HIGH, 32'h7fff); end
            1: begin write_reg(REG_CUTOFF_LOW, 32'd5000); write_reg(REG_CUTOFF_HIGH, 32'd28000);
                  write_reg(REG_MAG_TOL, 32'd0); end
            2: begin write_reg(REG_CUTOFF_LOW, 32'd100); write_reg(REG_CUTOFF_HIGH, 32'd32000);
                  write_reg(REG_MAG_TOL, 32'd536870); end
            default: write_reg(REG_MAG_TOL, 32'd53687);
         endcase
         if (ph == 1) begin
            hold_off = 1;
            fork
               begin repeat (3000) @(posedge clock); hold_off = 0; end
               for (int i = 0; i < 20; i++) push(make_voxel(1));
            join
            @(negedge clock) req_valid <= 0;
         end
         for (int i = 0; i < 280; i++) send(make_voxel($urandom_range(0, 4) != 0));
         @(negedge clock) req_valid <= 0;
         drain();
      end
      if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

[sim.f]
+incdir+src
src/vfaes_pkg.sv
src/vfaes_csr.sv
src/vector_field_angle_error_stats_unit.sv
tb/tb_vector_field_angle_error_stats_unit.sv
